// File: sv/hls_pkg.sv
// Package: types and constants for the heightmap line-of-sight block.
package hls_pkg;

	localparam int MAX_COLS  = 512;
	localparam int MAX_ROWS  = 512;
	localparam int ELEV_BITS = 8;
	localparam int COL_BITS  = $clog2(MAX_COLS);
	localparam int ROW_BITS  = $clog2(MAX_ROWS);
	localparam int ADDR_BITS = COL_BITS + ROW_BITS;
	localparam int DEPTH     = MAX_COLS * MAX_ROWS;

	localparam logic [1:0] REG_VIEWER_X   = 2'd0;
	localparam logic [1:0] REG_VIEWER_Y   = 2'd1;
	localparam logic [1:0] REG_MAP_WIDTH  = 2'd2;
	localparam logic [1:0] REG_MAP_HEIGHT = 2'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic       command;
		logic [8:0] cell_x;
		logic [8:0] cell_y;
		logic [7:0] elevation;
	} in_item_t;

	typedef struct packed {
		logic [8:0] query_x;
		logic [8:0] query_y;
		logic       visible;
		logic       bad_coord;
	} out_item_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;      // capture request and set up the walk
		logic wr_mem;    // store the request's elevation
		logic rd_view;   // read viewer elevation
		logic rd_targ;   // read target elevation
		logic step;      // advance the point counter and read that point
		logic cmp;       // compare the point read last
		logic finish;    // latch the result
	} dp_cmd_t;

	typedef struct packed {
		logic is_query;
		logic in_map;    // write target inside the map
		logic direct;    // query answered without a walk
		logic walk_done; // next counter value reaches D
		logic hidden;    // comparison found a blocker
	} dp_stat_t;

endpackage

// File: sv/hls_datapath.sv
// Datapath: heightmap memory, DDA point generator and angle comparison.
module hls_datapath import hls_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  req,
	input  logic      cfg_en,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat,
	output out_item_t result
);

	logic [8:0] vx_q, vy_q;
	logic [9:0] mw_q, mh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx_q <= 9'd245;
			vy_q <= 9'd497;
			mw_q <= 10'd512;
			mh_q <= 10'd512;
		end else if (cfg_en) begin
			unique case (cfg_index)
				REG_VIEWER_X:   vx_q <= cfg_data[8:0];
				REG_VIEWER_Y:   vy_q <= cfg_data[8:0];
				REG_MAP_WIDTH:  mw_q <= cfg_data;
				REG_MAP_HEIGHT: mh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [9:0] w_lim, h_lim;
	assign w_lim = (mw_q < 10'(MAX_COLS)) ? mw_q : 10'(MAX_COLS);
	assign h_lim = (mh_q < 10'(MAX_ROWS)) ? mh_q : 10'(MAX_ROWS);

	logic t_in, v_in;
	assign t_in = ({1'b0, req.cell_x} < w_lim) && ({1'b0, req.cell_y} < h_lim);
	assign v_in = ({1'b0, vx_q} < w_lim) && ({1'b0, vy_q} < h_lim);

	// Request hold and walk geometry.
	in_item_t   req_q;
	logic       bad_q, self_q;
	logic       sx_q, sy_q;           // sign of dx, dy
	logic [8:0] adx_q, ady_q, bigd_q;
	logic [18:0] rt_q;
	logic [8:0] i_q;
	logic [17:0] nx_q, ny_q;          // running i*|d|
	logic       vis_q;

	logic [9:0] dxs, dys;
	logic [8:0] adx, ady;
	assign dxs = {1'b0, req.cell_x} - {1'b0, vx_q};
	assign dys = {1'b0, req.cell_y} - {1'b0, vy_q};
	assign adx = dxs[9] ? 9'(-dxs) : dxs[8:0];
	assign ady = dys[9] ? 9'(-dys) : dys[8:0];

	// Rounded offsets: q = floor((2n + D) / 2D), found by a bounded search
	// over a running quotient; since n grows by at most D per step, the
	// quotient grows by at most one.
	logic [8:0] qx_q, qy_q;
	logic [19:0] rx_q, ry_q;          // 2n + D - q*2D
	logic [19:0] rx_n, ry_n, two_d;
	logic [8:0] qx_n, qy_n;
	assign two_d = {10'd0, bigd_q, 1'b0};

	always_comb begin
		rx_n = rx_q + {10'd0, adx_q, 1'b0};
		qx_n = qx_q;
		if (rx_n >= two_d) begin
			rx_n = rx_n - two_d;
			qx_n = qx_q + 9'd1;
		end
		ry_n = ry_q + {10'd0, ady_q, 1'b0};
		qy_n = qy_q;
		if (ry_n >= two_d) begin
			ry_n = ry_n - two_d;
			qy_n = qy_q + 9'd1;
		end
	end

	// Memory.
	logic [ELEV_BITS-1:0] mem [DEPTH];
	logic [ELEV_BITS-1:0] rd_q;
	logic [ADDR_BITS-1:0] rd_addr;
	logic [8:0] px, py;
	assign px = sx_q ? 9'(vx_q - qx_n) : 9'(vx_q + qx_n);
	assign py = sy_q ? 9'(vy_q - qy_n) : 9'(vy_q + qy_n);

	always_comb begin
		priority if (cmd.rd_view)
			rd_addr = {vy_q[ROW_BITS-1:0], vx_q[COL_BITS-1:0]};
		else if (cmd.rd_targ)
			rd_addr = {req_q.cell_y[ROW_BITS-1:0], req_q.cell_x[COL_BITS-1:0]};
		else
			rd_addr = {py[ROW_BITS-1:0], px[COL_BITS-1:0]};
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_mem)
			mem[{req_q.cell_y[ROW_BITS-1:0], req_q.cell_x[COL_BITS-1:0]}] <=
				req_q.elevation[ELEV_BITS-1:0];
		rd_q <= mem[rd_addr];
	end

	// Point metadata is registered alongside the read data.
	logic [8:0] ox_q, oy_q;
	logic       pvalid_q;
	logic [ELEV_BITS-1:0] vz_q;
	logic signed [ELEV_BITS:0] ht_q;
	logic rd_view_q, rd_targ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q  <= 1'b0;
			rd_view_q <= 1'b0;
			rd_targ_q <= 1'b0;
		end else begin
			pvalid_q  <= cmd.step && (qx_n != 9'd0 || qy_n != 9'd0);
			rd_view_q <= cmd.rd_view;
			rd_targ_q <= cmd.rd_targ;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req;
			bad_q  <= !t_in || !v_in;
			self_q <= (req.cell_x == vx_q) && (req.cell_y == vy_q);
			sx_q   <= dxs[9];
			sy_q   <= dys[9];
			adx_q  <= adx;
			ady_q  <= ady;
			bigd_q <= (adx > ady) ? adx : ady;
			rt_q   <= 19'(adx * adx) + 19'(ady * ady);
			i_q    <= 9'd0;
			qx_q   <= 9'd0;
			qy_q   <= 9'd0;
			rx_q   <= {11'd0, (adx > ady) ? adx : ady};
			ry_q   <= {11'd0, (adx > ady) ? adx : ady};
		end
		if (cmd.step) begin
			i_q  <= i_q + 9'd1;
			qx_q <= qx_n;
			qy_q <= qy_n;
			rx_q <= rx_n;
			ry_q <= ry_n;
			ox_q <= qx_n;
			oy_q <= qy_n;
		end
		if (rd_view_q)
			vz_q <= rd_q;
		if (rd_targ_q)
			ht_q <= $signed({1'b0, rd_q}) - $signed({1'b0, vz_q});
	end

	// Compare stage: squares and radius, registered before the products.
	logic signed [ELEV_BITS:0] hc;
	logic [ELEV_BITS-1:0] ahc, aht;
	logic [2*ELEV_BITS-1:0] hc2_s1, ht2_s1;
	logic [18:0] rc_s1;
	logic        hcn_s1, htn_s1, v_s1;
	logic [2*ELEV_BITS+18:0] lhs_s2, rhs_s2;
	logic        hcn_s2, htn_s2, v_s2;
	assign hc  = $signed({1'b0, rd_q}) - $signed({1'b0, vz_q});
	assign ahc = hc[ELEV_BITS] ? ELEV_BITS'(-hc) : hc[ELEV_BITS-1:0];
	assign aht = ht_q[ELEV_BITS] ? ELEV_BITS'(-ht_q) : ht_q[ELEV_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= pvalid_q && cmd.cmp;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		hc2_s1 <= ahc * ahc;
		ht2_s1 <= aht * aht;
		rc_s1  <= 19'(ox_q * ox_q) + 19'(oy_q * oy_q);
		hcn_s1 <= hc[ELEV_BITS];
		htn_s1 <= ht_q[ELEV_BITS];
		lhs_s2 <= hc2_s1 * rt_q;
		rhs_s2 <= ht2_s1 * rc_s1;
		hcn_s2 <= hcn_s1;
		htn_s2 <= htn_s1;
	end

	logic ge;
	always_comb begin
		unique case ({hcn_s2, htn_s2})
			2'b01:   ge = 1'b1;
			2'b10:   ge = 1'b0;
			2'b00:   ge = lhs_s2 >= rhs_s2;
			default: ge = lhs_s2 <= rhs_s2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			vis_q <= 1'b1;
		else if (v_s2 && ge)
			vis_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result.query_x   <= req_q.cell_x;
			result.query_y   <= req_q.cell_y;
			result.bad_coord <= bad_q;
			result.visible   <= !bad_q && (self_q || vis_q);
		end
	end

	assign stat.is_query  = req_q.command == CMD_QUERY;
	assign stat.in_map    =
		({1'b0, req_q.cell_x} < w_lim) && ({1'b0, req_q.cell_y} < h_lim);
	assign stat.direct    = bad_q || self_q;
	assign stat.walk_done = (i_q + 9'd1) >= bigd_q;
	assign stat.hidden    = v_s2 && ge;

endmodule

// File: sv/hls_ctrl.sv
// Controller: sequences writes and the line walk of each query.
module hls_ctrl import hls_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic     out_stall,
	output logic     out_valid,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DECO  = 8'b0000_0010,
		ST_VIEW  = 8'b0000_0100,
		ST_TARG  = 8'b0000_1000,
		ST_WALK  = 8'b0001_0000,
		ST_DRAIN = 8'b0010_0000,
		ST_DONE  = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q, state_n;
	logic [1:0] drain_q;
	logic out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid)
					state_n = ST_DECO;
			end
			ST_DECO: begin
				priority if (!stat.is_query) begin
					cmd.wr_mem = stat.in_map;
					state_n = ST_IDLE;
				end else if (stat.direct)
					state_n = ST_DONE;
				else begin
					cmd.rd_view = 1'b1;
					state_n = ST_VIEW;
				end
			end
			ST_VIEW: begin
				cmd.rd_targ = 1'b1;
				state_n = ST_TARG;
			end
			ST_TARG: begin
				state_n = stat.walk_done ? ST_DRAIN : ST_WALK;
				cmd.step = !stat.walk_done;
			end
			ST_WALK: begin
				cmd.cmp = 1'b1;
				priority if (stat.hidden)
					state_n = ST_DONE;
				else if (stat.walk_done)
					state_n = ST_DRAIN;
				else
					cmd.step = 1'b1;
			end
			ST_DRAIN: begin
				cmd.cmp = 1'b1;
				if (drain_q == 2'd3 || stat.hidden)
					state_n = ST_DONE;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_n = ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall)
					state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			drain_q     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			drain_q <= (state_q == ST_DRAIN) ? drain_q + 2'd1 : 2'd0;
			if (state_q == ST_DONE)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// File: sv/heightmap_line_of_sight.sv
// Top level of the heightmap line-of-sight block.
// A write request stores one elevation in the on-chip heightmap (one
// memory, MAX_COLS*MAX_ROWS entries, undefined until written). A query
// request walks the DDA line from the viewer to the target one point per
// cycle through the single memory read port, with D = max(|dx|,|dy|)
// giving the line length. The walk stops early at the first blocking
// point. One request is in the block at a time; a query result holds on
// the output until taken, then the next request is accepted.
// Configuration writes go to the four registers in order viewer_x,
// viewer_y, map_width, map_height; write them only while idle.
module heightmap_line_of_sight import hls_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_en,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Hold the request in the datapath and sequence it from the controller.
	hls_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_stall(out_stall), .out_valid(out_valid),
		.stat(stat), .cmd(cmd)
	);

	hls_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .req(in_data),
		.cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .stat(stat), .result(out_data)
	);

`ifndef SYNTHESIS
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("request taken with result pending");
	a_finish_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid) else $error("result not presented");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !out_valid) else $error("load while result pending");
`endif

endmodule

// File: test/tb.sv
// Testbench for the heightmap line-of-sight block: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb;
	import hls_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_en;
	logic [1:0] cfg_index;
	logic [9:0] cfg_data;

	heightmap_line_of_sight dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state: own copy of registers and heightmap, plus a mark of
	// which cells have been written so that no query reads an unset cell.
	int unsigned view_col, view_row, cols_cfg, rows_cfg;
	logic [7:0]  height_map [0:DEPTH-1];
	bit          height_set [0:DEPTH-1];
	out_item_t   pending_answers [$];

	int errors;
	int requests_sent;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_off_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous fixed limit on the whole run.
	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

	function automatic int unsigned used_cols();
		return (cols_cfg < MAX_COLS) ? cols_cfg : MAX_COLS;
	endfunction

	function automatic int unsigned used_rows();
		return (rows_cfg < MAX_ROWS) ? rows_cfg : MAX_ROWS;
	endfunction

	// Rounded offset of line point i: round half away from zero of i*d/big_d.
	function automatic int line_offset(int i, int d, int big_d);
		int mag;
		int q;
		mag = (d < 0) ? -d : d;
		q = (2 * i * mag + big_d) / (2 * big_d);
		return (d < 0) ? -q : q;
	endfunction

	// Elevation angle of a point at least that of the target, by cross-multiplication.
	function automatic bit blocks_sight(longint hc, longint rc, longint ht, longint rt);
		if (hc >= 0 && ht < 0)
			return 1'b1;
		if (hc < 0 && ht >= 0)
			return 1'b0;
		if (hc >= 0)
			return hc * hc * rt >= ht * ht * rc;
		return hc * hc * rt <= ht * ht * rc;
	endfunction

	function automatic bit sight_clear(int unsigned tx, int unsigned ty);
		int  vx, vy, dx, dy, big_d, ox, oy, i;
		longint vz, ht, rt, hc, rc;
		vx = view_col;
		vy = view_row;
		dx = int'(tx) - vx;
		dy = int'(ty) - vy;
		big_d = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) ?
			(dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy);
		vz = height_map[vy * MAX_COLS + vx];
		ht = longint'(height_map[ty * MAX_COLS + tx]) - vz;
		rt = dx * dx + dy * dy;
		for (i = 1; i < big_d; i++) begin
			ox = line_offset(i, dx, big_d);
			oy = line_offset(i, dy, big_d);
			if (ox == 0 && oy == 0)
				continue;
			hc = longint'(height_map[(vy + oy) * MAX_COLS + vx + ox]) - vz;
			rc = ox * ox + oy * oy;
			if (blocks_sight(hc, rc, ht, rt))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Apply one accepted request to the predictor; queue the answer of a query.
	function automatic void predict_request(in_item_t req);
		bit        target_in, viewer_in;
		out_item_t ans;
		target_in = req.cell_x < used_cols() && req.cell_y < used_rows();
		viewer_in = view_col < used_cols() && view_row < used_rows();
		if (req.command == CMD_WRITE) begin
			if (target_in) begin
				height_map[req.cell_y * MAX_COLS + req.cell_x] = req.elevation;
				height_set[req.cell_y * MAX_COLS + req.cell_x] = 1'b1;
			end
			return;
		end
		ans.query_x = req.cell_x;
		ans.query_y = req.cell_y;
		ans.visible = 1'b0;
		ans.bad_coord = 1'b0;
		if (!target_in || !viewer_in)
			ans.bad_coord = 1'b1;
		else if (req.cell_x == view_col && req.cell_y == view_row)
			ans.visible = 1'b1;
		else
			ans.visible = sight_clear(req.cell_x, req.cell_y);
		pending_answers.push_back(ans);
	endfunction

	// Offer one request, idling at random first; valid stays high on return.
	task automatic send_request(in_item_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		// in_stall only moves at an edge, so read it mid-cycle
		do
			@(negedge clk);
		while (in_stall);
		@(posedge clk);
		predict_request(req);
		requests_sent++;
	endtask

	task automatic write_height(int unsigned x, int unsigned y, int unsigned elev);
		in_item_t req;
		req.command = CMD_WRITE;
		req.cell_x = 9'(x);
		req.cell_y = 9'(y);
		req.elevation = 8'(elev);
		send_request(req);
	endtask

	function automatic int unsigned pick_height();
		case ($urandom_range(3))
			0: return $urandom_range(255);
			1: return $urandom_range(15);
			2: return $urandom_range(255, 240);
			default: return $urandom_range(40, 90);
		endcase
	endfunction

	// Query a cell, first writing any unset cell that the walk may read.
	task automatic query_cell(int unsigned tx, int unsigned ty);
		int       dx, dy, big_d, i, px, py;
		in_item_t req;
		if (tx < used_cols() && ty < used_rows() && view_col < used_cols() &&
				view_row < used_rows()) begin
			dx = int'(tx) - int'(view_col);
			dy = int'(ty) - int'(view_row);
			big_d = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) ?
				(dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy);
			for (i = 0; i <= big_d; i++) begin
				px = (big_d == 0) ? view_col : view_col + line_offset(i, dx, big_d);
				py = (big_d == 0) ? view_row : view_row + line_offset(i, dy, big_d);
				if (!height_set[py * MAX_COLS + px])
					write_height(px, py, pick_height());
			end
		end
		req.command = CMD_QUERY;
		req.cell_x = 9'(tx);
		req.cell_y = 9'(ty);
		req.elevation = 8'($urandom_range(255));
		send_request(req);
	endtask

	// Drop valid, wait for every answer, then let a trailing write finish.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned value);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 10'(value);
		@(posedge clk);
		cfg_en <= 1'b0;
		case (idx)
			REG_VIEWER_X:   view_col = value & 9'h1FF;
			REG_VIEWER_Y:   view_row = value & 9'h1FF;
			REG_MAP_WIDTH:  cols_cfg = value & 10'h3FF;
			REG_MAP_HEIGHT: rows_cfg = value & 10'h3FF;
			default: ;
		endcase
	endtask

	task automatic set_map(int unsigned vx, int unsigned vy, int unsigned w, int unsigned h);
		settle();
		write_reg(REG_VIEWER_X, vx);
		write_reg(REG_VIEWER_Y, vy);
		write_reg(REG_MAP_WIDTH, w);
		write_reg(REG_MAP_HEIGHT, h);
	endtask

	// Receiver: random stall, or a counted hold-off when one is asked for.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			out_stall <= 1'b1;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Take each answer mid-cycle, ahead of the edge that accepts it.
	always @(negedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected answer %p", $time, out_data);
				errors++;
			end else begin
				want = pending_answers.pop_front();
				if (out_data.query_x !== want.query_x || out_data.query_y !== want.query_y ||
						out_data.visible !== want.visible ||
						out_data.bad_coord !== want.bad_coord) begin
					$display("%0t: expected %p, got %p", $time, want, out_data);
					errors++;
				end
			end
		end
	end

	// Extremes, the viewer cell, out-of-map cases and register corners.
	task automatic test_directed();
		in_item_t req;
		// reset registers: viewer at (245,497) on a full map
		write_height(245, 497, 255);
		query_cell(245, 497);
		query_cell(250, 511);        // bottom row of the full map
		write_height(245, 497, 0);
		query_cell(245, 500);
		query_cell(230, 497);
		set_map(5, 5, 16, 16);
		write_height(20, 3, 77);     // outside the map, ignored
		query_cell(20, 3);
		query_cell(3, 16);
		query_cell(5, 5);
		query_cell(0, 0);
		query_cell(15, 15);
		query_cell(15, 6);           // half-way rounding on a shallow line
		write_height(10, 5, 255);
		query_cell(15, 5);
		set_map(300, 5, 16, 16);     // viewer off the map
		query_cell(3, 3);
		set_map(0, 0, 0, 0);         // empty map
		query_cell(0, 0);
		req.command = CMD_WRITE;
		req.cell_x = 0;
		req.cell_y = 0;
		req.elevation = 8'hFF;
		send_request(req);
		set_map(511, 0, 1023, 1);    // oversize width clamps to the maximum
		query_cell(500, 0);
		query_cell(511, 1);
		set_map(0, 511, 1, 512);
		query_cell(0, 500);
	endtask

	task automatic test_random(int count);
		int target;
		int n;
		int unsigned w, h;
		target = requests_sent + count;
		while (requests_sent < target) begin
			// small maps keep the walks short
			w = $urandom_range(40, 1);
			h = $urandom_range(40, 1);
			if ($urandom_range(7) == 0)
				set_map($urandom_range(511), $urandom_range(511), w, h);
			else
				set_map($urandom_range(w - 1), $urandom_range(h - 1), w, h);
			for (n = 0; n < 40 && requests_sent < target; n++) begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4: query_cell($urandom_range(used_cols() - 1),
						$urandom_range(used_rows() - 1));
					5, 6: write_height($urandom_range(used_cols() - 1),
						$urandom_range(used_rows() - 1), pick_height());
					7: write_height($urandom_range(511), $urandom_range(511),
						$urandom_range(255));
					default: query_cell($urandom_range(511), $urandom_range(511));
				endcase
			end
		end
	endtask

	// Hold the output off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		set_map(2, 2, 8, 8);
		hold_off_cycles = 400;
		repeat (12)
			query_cell($urandom_range(7), $urandom_range(7));
	endtask

	initial begin
		errors = 0;
		requests_sent = 0;
		send_idle_pct = 28;
		recv_idle_pct = 82;
		hold_off_cycles = 0;
		view_col = 245;
		view_row = 497;
		cols_cfg = 512;
		rows_cfg = 512;
		foreach (height_set[i])
			height_set[i] = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_en = 1'b0;
		cfg_index = REG_VIEWER_X;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(145);
		send_idle_pct = 82;
		recv_idle_pct = 28;
		test_random(145);
		test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(145);

		settle();
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
